// File: rtl/core/plb_pkg.sv
// Shared types and constants for the positional list buffer.
`timescale 1ns / 1ps

package plb_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    // Cell index width that covers depths up to 128
    localparam int unsigned IDX_W     = 7;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned LEN_W     = 5;
    localparam int unsigned POS_W     = 5;

    typedef enum logic [2:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_INS_POS   = 3'd2,
        REQ_DEL_FRONT = 3'd3,
        REQ_DEL_BACK  = 3'd4,
        REQ_DEL_POS   = 3'd5,
        REQ_READ      = 3'd6
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } t_cell_op;

    // Broadcast to every cell; each cell compares idx with its own place
    typedef struct packed {
        t_cell_op           op;
        logic [IDX_W-1:0]   idx;
    } t_cmd;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

endpackage

// File: rtl/core/plb_cell.sv
// One storage cell of the list chain.
`timescale 1ns / 1ps

module plb_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                                i_clk,
    input  plb_pkg::t_cmd                       i_cmd,
    input  logic signed [plb_pkg::DATA_W-1:0]   i_ins,
    input  logic signed [plb_pkg::DATA_W-1:0]   i_left,
    input  logic signed [plb_pkg::DATA_W-1:0]   i_right,
    input  logic signed [plb_pkg::DATA_W-1:0]   i_head,
    output logic signed [plb_pkg::DATA_W-1:0]   o_val
);

    localparam logic [plb_pkg::IDX_W-1:0] MY_IDX = plb_pkg::IDX_W'(IDX);

    logic signed [plb_pkg::DATA_W-1:0] r_val;
    logic signed [plb_pkg::DATA_W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        unique case (i_cmd.op)
            plb_pkg::CELL_INSERT: begin
                if (MY_IDX == i_cmd.idx) begin
                    n_val = i_ins;
                end else if (MY_IDX > i_cmd.idx) begin
                    n_val = i_left;
                end
            end
            plb_pkg::CELL_REMOVE: begin
                if (MY_IDX >= i_cmd.idx) begin
                    n_val = i_right;
                end
            end
            // idx marks the tail; it takes the head so the list wraps around
            plb_pkg::CELL_ROTATE: begin
                if (MY_IDX == i_cmd.idx) begin
                    n_val = i_head;
                end else if (MY_IDX < i_cmd.idx) begin
                    n_val = i_right;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

// File: rtl/core/positional_list_buffer.sv
// Top level: request decode, list control and the chain of storage cells.
// Insert/delete/no-op requests: one result, registered and shown in the cycle after the beat is taken;
// such requests can be taken every cycle while the result side keeps up.
// Readout of N elements: the read state loads them one per cycle while the result side keeps up,
// rotating the chain one cell per element; the next request is taken once the last one is out.
// Synchronous active-low reset empties the list and drops the output valid.
`timescale 1ns / 1ps

module positional_list_buffer #(
    parameter int unsigned DEPTH = plb_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [2:0]                          i_req_type,
    input  logic signed [plb_pkg::DATA_W-1:0]   i_value,
    input  logic [plb_pkg::POS_W-1:0]           i_position,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_out_status,
    output logic signed [plb_pkg::DATA_W-1:0]   o_out_element,
    output logic [plb_pkg::LEN_W-1:0]           o_out_length,
    output logic                                o_out_last
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CMP_W = ((CNT_W > plb_pkg::POS_W) ? CNT_W : plb_pkg::POS_W) + 1;

    plb_pkg::t_state                    r_state;
    plb_pkg::t_state                    n_state;
    logic [CNT_W-1:0]                   r_count;
    logic [CNT_W-1:0]                   n_count;
    logic [CNT_W-1:0]                   r_rd_left;
    logic [CNT_W-1:0]                   n_rd_left;
    logic                               r_out_valid;
    logic                               n_out_valid;
    plb_pkg::t_status                   r_out_status;
    plb_pkg::t_status                   n_out_status;
    logic signed [plb_pkg::DATA_W-1:0]  r_out_element;
    logic signed [plb_pkg::DATA_W-1:0]  n_out_element;
    logic [plb_pkg::LEN_W-1:0]          r_out_length;
    logic                               r_out_last;
    logic                               n_out_last;
    logic                               n_load;

    plb_pkg::t_cmd                      w_cmd;
    logic                               w_out_free;
    logic                               w_accept;
    logic                               w_full;
    logic [CMP_W-1:0]                   w_pos_ext;
    logic [CMP_W-1:0]                   w_cnt_ext;
    logic [CMP_W-1:0]                   w_ncnt_ext;
    logic signed [plb_pkg::DATA_W-1:0]  w_cell [DEPTH];

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == plb_pkg::S_IDLE) && w_out_free);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_pos_ext  = CMP_W'(i_position);
    assign w_cnt_ext  = CMP_W'(r_count);
    assign w_ncnt_ext = CMP_W'(n_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plb_pkg::S_IDLE: begin
                if (w_accept && (plb_pkg::t_req'(i_req_type) == plb_pkg::REQ_READ)
                        && (r_count != '0)) begin
                    n_state = plb_pkg::S_READ;
                end
            end
            plb_pkg::S_READ: begin
                if (w_out_free && (r_rd_left == CNT_W'(1))) begin
                    n_state = plb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = plb_pkg::S_IDLE;
            end
        endcase
    end

    // outputs: chain command, count update and result register load
    always_comb begin
        w_cmd.op      = plb_pkg::CELL_HOLD;
        w_cmd.idx     = '0;
        n_count       = r_count;
        n_rd_left     = r_rd_left;
        n_load        = 1'b0;
        n_out_status  = r_out_status;
        n_out_element = r_out_element;
        n_out_last    = r_out_last;
        unique case (r_state)
            plb_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_load        = 1'b1;
                    n_out_status  = plb_pkg::ST_OK;
                    n_out_element = '0;
                    n_out_last    = 1'b1;
                    unique case (plb_pkg::t_req'(i_req_type))
                        plb_pkg::REQ_INS_FRONT: begin
                            if (w_full) begin
                                n_out_status = plb_pkg::ST_FULL;
                            end else begin
                                w_cmd.op  = plb_pkg::CELL_INSERT;
                                w_cmd.idx = '0;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        plb_pkg::REQ_INS_BACK: begin
                            if (w_full) begin
                                n_out_status = plb_pkg::ST_FULL;
                            end else begin
                                w_cmd.op  = plb_pkg::CELL_INSERT;
                                w_cmd.idx = plb_pkg::IDX_W'(r_count);
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        plb_pkg::REQ_INS_POS: begin
                            if ((i_position == '0) || (w_pos_ext > w_cnt_ext + CMP_W'(1))) begin
                                n_out_status = plb_pkg::ST_BADPOS;
                            end else if (w_full) begin
                                n_out_status = plb_pkg::ST_FULL;
                            end else begin
                                w_cmd.op  = plb_pkg::CELL_INSERT;
                                w_cmd.idx = plb_pkg::IDX_W'(i_position - plb_pkg::POS_W'(1));
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        plb_pkg::REQ_DEL_FRONT: begin
                            if (r_count == '0) begin
                                n_out_status = plb_pkg::ST_EMPTY;
                            end else begin
                                w_cmd.op  = plb_pkg::CELL_REMOVE;
                                w_cmd.idx = '0;
                                n_count   = r_count - CNT_W'(1);
                            end
                        end
                        plb_pkg::REQ_DEL_BACK: begin
                            if (r_count == '0) begin
                                n_out_status = plb_pkg::ST_EMPTY;
                            end else begin
                                w_cmd.op  = plb_pkg::CELL_REMOVE;
                                w_cmd.idx = plb_pkg::IDX_W'(r_count - CNT_W'(1));
                                n_count   = r_count - CNT_W'(1);
                            end
                        end
                        plb_pkg::REQ_DEL_POS: begin
                            if (r_count == '0) begin
                                n_out_status = plb_pkg::ST_EMPTY;
                            end else if ((i_position == '0) || (w_pos_ext > w_cnt_ext)) begin
                                n_out_status = plb_pkg::ST_BADPOS;
                            end else begin
                                w_cmd.op  = plb_pkg::CELL_REMOVE;
                                w_cmd.idx = plb_pkg::IDX_W'(i_position - plb_pkg::POS_W'(1));
                                n_count   = r_count - CNT_W'(1);
                            end
                        end
                        plb_pkg::REQ_READ: begin
                            if (r_count == '0) begin
                                n_out_status = plb_pkg::ST_EMPTY;
                            end else begin
                                // elements follow from the read state
                                n_load    = 1'b0;
                                n_rd_left = r_count;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            plb_pkg::S_READ: begin
                if (w_out_free) begin
                    n_load        = 1'b1;
                    n_out_status  = plb_pkg::ST_OK;
                    n_out_element = w_cell[0];
                    n_out_last    = (r_rd_left == CNT_W'(1));
                    w_cmd.op      = plb_pkg::CELL_ROTATE;
                    w_cmd.idx     = plb_pkg::IDX_W'(r_count - CNT_W'(1));
                    n_rd_left     = r_rd_left - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
        n_out_valid = n_load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plb_pkg::S_IDLE;
            r_count     <= '0;
            r_rd_left   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_left   <= n_rd_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out_status  <= n_out_status;
            r_out_element <= n_out_element;
            r_out_length  <= w_ncnt_ext[plb_pkg::LEN_W-1:0];
            r_out_last    <= n_out_last;
        end
    end

    // chain: each cell sees its neighbors; the head feeds the tail on rotate
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [plb_pkg::DATA_W-1:0] w_left;
        logic signed [plb_pkg::DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_cell[g];
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end
        plb_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_ins   (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_cell[0]),
            .o_val   (w_cell[g])
        );
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_status  = r_out_status;
    assign o_out_element = r_out_element;
    assign o_out_length  = r_out_length;
    assign o_out_last    = r_out_last;

endmodule

// File: rtl/core/plb_checker.sv
// Port-level checks for the positional list buffer, bound to the top level.
`timescale 1ns / 1ps

module plb_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [1:0]                          o_out_status,
    input logic signed [plb_pkg::DATA_W-1:0]   o_out_element,
    input logic [plb_pkg::LEN_W-1:0]           o_out_length,
    input logic                                o_out_last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_element)
            && $stable(o_out_status) && $stable(o_out_length) && $stable(o_out_last)))
        else $error("result beat changed while stalled");

    // no new request while a readout is still streaming
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_last) |-> o_in_stall)
        else $error("request taken during readout");

    // failed requests carry no element and end the request
    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_status != plb_pkg::ST_OK)) |-> ((o_out_element == '0) && o_out_last))
        else $error("failed request result malformed");

    // empty status only with an empty list
    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_status == plb_pkg::ST_EMPTY)) |-> (o_out_length == '0))
        else $error("empty status with nonzero length");

endmodule

bind positional_list_buffer plb_checker u_plb_checker (.*);

// File: tb/sv/list_result_checker.sv
// Result checker for the positional list buffer: shadow list, expected results, comparison.
`timescale 1ns / 1ps

module list_result_checker #(
    parameter int unsigned DEPTH = plb_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [2:0]                          i_req_type,
    input  logic signed [plb_pkg::DATA_W-1:0]   i_value,
    input  logic [plb_pkg::POS_W-1:0]           i_position,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [1:0]                          i_out_status,
    input  logic signed [plb_pkg::DATA_W-1:0]   i_out_element,
    input  logic [plb_pkg::LEN_W-1:0]           i_out_length,
    input  logic                                i_out_last,
    output int                                  o_fail_count,
    output int                                  o_outstanding
);

    import plb_pkg::*;

    typedef struct {
        t_status                    status;
        logic signed [DATA_W-1:0]   element;
        logic [LEN_W-1:0]           length;
        logic                       last;
    } list_result_t;

    logic signed [DATA_W-1:0]   shadow_cells [DEPTH];
    int unsigned                shadow_count;
    list_result_t               pending_results [$];

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic push_result(input t_status st, input logic signed [DATA_W-1:0] elem,
                               input logic last);
        list_result_t r;
        r.status  = st;
        r.element = elem;
        r.length  = shadow_count[LEN_W-1:0];
        r.last    = last;
        pending_results.push_back(r);
    endtask

    task automatic insert_cell(input int unsigned idx, input logic signed [DATA_W-1:0] val,
                               output t_status st);
        int unsigned i;
        if (shadow_count >= DEPTH) begin
            st = ST_FULL;
        end else begin
            for (i = shadow_count; i > idx; i--)
                shadow_cells[i] = shadow_cells[i-1];
            shadow_cells[idx] = val;
            shadow_count++;
            st = ST_OK;
        end
    endtask

    task automatic remove_cell(input int unsigned idx);
        int unsigned i;
        for (i = idx; i + 1 < shadow_count; i++)
            shadow_cells[i] = shadow_cells[i+1];
        shadow_count--;
    endtask

    task automatic predict_request(input logic [2:0] req, input logic signed [DATA_W-1:0] val,
                                   input logic [POS_W-1:0] pos);
        t_status     st;
        int unsigned i;
        st = ST_OK;
        case (req)
            REQ_INS_FRONT: insert_cell(0, val, st);
            REQ_INS_BACK:  insert_cell(shadow_count, val, st);
            REQ_INS_POS: begin
                // position check comes ahead of the full check
                if (pos == 0 || pos > shadow_count + 1)
                    st = ST_BADPOS;
                else
                    insert_cell(pos - 1, val, st);
            end
            REQ_DEL_FRONT: begin
                if (shadow_count == 0) st = ST_EMPTY;
                else remove_cell(0);
            end
            REQ_DEL_BACK: begin
                if (shadow_count == 0) st = ST_EMPTY;
                else remove_cell(shadow_count - 1);
            end
            REQ_DEL_POS: begin
                if (shadow_count == 0) st = ST_EMPTY;
                else if (pos == 0 || pos > shadow_count) st = ST_BADPOS;
                else remove_cell(pos - 1);
            end
            REQ_READ: begin
                if (shadow_count == 0) begin
                    push_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (i = 0; i < shadow_count; i++)
                        push_result(ST_OK, shadow_cells[i], (i + 1 == shadow_count));
                end
                return;
            end
            default: ;  // spare code: no change, plain ok result
        endcase
        push_result(st, '0, 1'b1);
    endtask

    always @(posedge i_clk) begin : watch_channels
        list_result_t want;
        if (!i_rst_n) begin
            foreach (shadow_cells[k])
                shadow_cells[k] = '0;
            shadow_count = 0;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding");
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_out_status, want.status));
                    if (i_out_element !== want.element)
                        report_mismatch($sformatf("element got %0d want %0d",
                                                  i_out_element, want.element));
                    if (i_out_length !== want.length)
                        report_mismatch($sformatf("length got %0d want %0d",
                                                  i_out_length, want.length));
                    if (i_out_last !== want.last)
                        report_mismatch($sformatf("last got %0b want %0b",
                                                  i_out_last, want.last));
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_request(i_req_type, i_value, i_position);
        end
        o_outstanding = pending_results.size();
    end

endmodule

// File: tb/sv/tb_positional_list_buffer.sv
// Testbench top for the positional list buffer: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_positional_list_buffer;

    import plb_pkg::*;

    localparam int unsigned LIST_DEPTH   = DEPTH_DEF;
    localparam logic [2:0]  REQ_SPARE    = 3'd7;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PHASE_ITEMS  = 52;
    localparam int          TAIL_CYCLES  = 40;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [2:0]                 i_req_type;
    logic signed [DATA_W-1:0]   i_value;
    logic [POS_W-1:0]           i_position;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [1:0]                 o_out_status;
    logic signed [DATA_W-1:0]   o_out_element;
    logic [LEN_W-1:0]           o_out_length;
    logic                       o_out_last;

    int          fail_count;
    int          outstanding;
    int          cycle_count;
    int          hold_asked;
    int          list_len;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    positional_list_buffer #(.DEPTH(LIST_DEPTH)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_status  (o_out_status),
        .o_out_element (o_out_element),
        .o_out_length  (o_out_length),
        .o_out_last    (o_out_last)
    );

    list_result_checker #(.DEPTH(LIST_DEPTH)) result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_position    (i_position),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_status  (o_out_status),
        .i_out_element (o_out_element),
        .i_out_length  (o_out_length),
        .i_out_last    (o_out_last),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random stalls per phase, plus long hold-offs on request
    initial begin : result_side
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_asked) begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] any_pos();
        return POS_W'($urandom_range(31));
    endfunction

    // Rough element count kept on the stimulus side only to aim positions and steer inserts vs deletes
    function automatic void track_len(input logic [2:0] req, input logic [POS_W-1:0] pos);
        case (req)
            REQ_INS_FRONT, REQ_INS_BACK: if (list_len < LIST_DEPTH) list_len++;
            REQ_INS_POS:   if (pos >= 1 && pos <= list_len + 1 && list_len < LIST_DEPTH)
                               list_len++;
            REQ_DEL_FRONT, REQ_DEL_BACK: if (list_len > 0) list_len--;
            REQ_DEL_POS:   if (list_len > 0 && pos >= 1 && pos <= list_len) list_len--;
            default: ;
        endcase
    endfunction

    task automatic send_beat(input logic [2:0] req, input logic signed [DATA_W-1:0] val,
                             input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_value    <= val;
        i_position <= pos;
        do @(posedge i_clk); while (o_in_stall);
        track_len(req, pos);
    endtask

    task automatic send_insert();
        case ($urandom_range(2))
            0:       send_beat(REQ_INS_FRONT, pick_value(), any_pos());
            1:       send_beat(REQ_INS_BACK, pick_value(), any_pos());
            default: send_beat(REQ_INS_POS, pick_value(),
                               POS_W'($urandom_range(list_len + 1, 1)));
        endcase
    endtask

    task automatic send_random_beat();
        int unsigned roll;
        int unsigned grow_pct;
        roll = $urandom_range(99);
        if (roll < 8) begin
            // noise: any code, any position
            send_beat(3'($urandom_range(7)), pick_value(), any_pos());
        end else if (roll < 18) begin
            send_beat(REQ_READ, $urandom, any_pos());
        end else begin
            grow_pct = (list_len < 4) ? 75 : (list_len > 12) ? 30 : 55;
            if ($urandom_range(99) < grow_pct) begin
                send_insert();
            end else begin
                case ($urandom_range(2))
                    0: send_beat(REQ_DEL_FRONT, $urandom, any_pos());
                    1: send_beat(REQ_DEL_BACK, $urandom, any_pos());
                    default: send_beat(REQ_DEL_POS, $urandom,
                                       (list_len == 0) ? POS_W'(1)
                                                       : POS_W'($urandom_range(list_len, 1)));
                endcase
            end
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        int p;
        int n;
        hold_asked     = 0;
        list_len       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_req_type <= REQ_READ;
        i_value    <= '0;
        i_position <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, bad positions, extremes, spare code
        send_beat(REQ_READ, $urandom, any_pos());
        send_beat(REQ_DEL_FRONT, $urandom, any_pos());
        send_beat(REQ_DEL_BACK, $urandom, any_pos());
        send_beat(REQ_DEL_POS, $urandom, 5'd0);
        send_beat(REQ_INS_POS, 32'sd5, 5'd0);
        send_beat(REQ_INS_POS, 32'sd6, 5'd2);
        send_beat(REQ_INS_FRONT, 32'sh7FFF_FFFF, 5'd31);
        send_beat(REQ_INS_BACK, 32'sh8000_0000, 5'd0);
        send_beat(REQ_INS_POS, 32'sd0, 5'd3);
        send_beat(REQ_INS_POS, -32'sd1, 5'd1);
        send_beat(REQ_INS_POS, 32'sd7, 5'd31);
        send_beat(REQ_SPARE, $urandom, any_pos());
        send_beat(REQ_READ, $urandom, 5'd0);
        send_beat(REQ_DEL_POS, $urandom, 5'd0);
        send_beat(REQ_DEL_POS, $urandom, 5'd5);
        send_beat(REQ_DEL_POS, $urandom, 5'd2);
        send_beat(REQ_DEL_BACK, $urandom, 5'd31);
        send_beat(REQ_DEL_FRONT, $urandom, 5'd31);
        send_beat(REQ_READ, $urandom, 5'd31);
        send_beat(REQ_DEL_POS, $urandom, 5'd1);
        send_beat(REQ_SPARE, $urandom, any_pos());
        wait_drained();

        // result side holds off while inserts keep coming: list fills, input backs up
        hold_asked++;
        for (n = 0; n < 20; n++)
            send_insert();
        send_beat(REQ_INS_POS, pick_value(), 5'd18);
        send_beat(REQ_INS_POS, pick_value(), 5'd17);
        send_beat(REQ_READ, $urandom, any_pos());
        wait_drained();

        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                send_random_beat();
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: positional_list_buffer.f
rtl/core/plb_pkg.sv
rtl/core/plb_cell.sv
rtl/core/positional_list_buffer.sv
rtl/core/plb_checker.sv
tb/sv/list_result_checker.sv
tb/sv/tb_positional_list_buffer.sv
